// ----- rtl/bffa_pkg.sv -----
// Package for the bitmap first-fit allocator: shared types, codes and defaults.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package bffa_pkg;

  localparam int HEAP_BYTES_DEF    = 4096;
  localparam int SEGMENT_BYTES_DEF = 16;

  localparam int SIZE_W   = 16;
  localparam int OFFSET_W = 12;
  // Wide enough for any byte count up to the largest heap and for any size.
  localparam int CMP_W    = 17;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_CLEAR = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_MARK
  } state_t;

  typedef struct packed {
    logic init;
    logic load;
    logic clr_wr;
    logic rd;
    logic chk;
    logic mark_init;
    logic mark_wr;
    logic resp_grant;
    logic resp_fail;
    logic resp_clear;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
    logic fit;
    logic mark_last;
  } dp_sts_t;

endpackage

`default_nettype wire

// ----- rtl/bitmap_first_fit_allocator_unit.sv -----
// A clear word writes every segment of the map free and then answers. An allocate
// word reads and checks segment after segment (one map read, one check) until a
// free run fits, marks each segment of that run and then gives the result.
// One word at a time; busy is high while a word is in work. The result strobe
// cannot be stalled. After reset a clearing pass over every segment runs first.
`default_nettype none

module bitmap_first_fit_allocator_unit #(
  parameter int HEAP_BYTES    = bffa_pkg::HEAP_BYTES_DEF,
  parameter int SEGMENT_BYTES = bffa_pkg::SEGMENT_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_kind,
  input  wire logic [bffa_pkg::SIZE_W-1:0]   in_size_bytes,
  output logic                               out_valid,
  output logic                               out_granted,
  output logic                               out_failed,
  output logic [bffa_pkg::OFFSET_W-1:0]      out_offset
);

  bffa_pkg::dp_cmd_t cmd;
  bffa_pkg::dp_sts_t sts;

  bffa_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_kind (in_kind),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  bffa_datapath #(
    .HEAP_BYTES    (HEAP_BYTES),
    .SEGMENT_BYTES (SEGMENT_BYTES)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_size_bytes (in_size_bytes),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_granted   (out_granted),
    .out_failed    (out_failed),
    .out_offset    (out_offset)
  );

  // Every accepted word keeps the block busy for at least the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not make the block busy");

  // A result is only given out once the block has returned to idle.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobed while the block is still busy");

  a_grant_fail_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_granted && out_failed))
    else $error("result both granted and failed");

  a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_granted) |-> (out_offset == '0))
    else $error("non-zero offset on a result that was not granted");

endmodule

`default_nettype wire

// ----- rtl/bffa_ctrl.sv -----
// Controller state machine of the bitmap first-fit allocator.
// Drives the datapath through bffa_pkg::dp_cmd_t and reads bffa_pkg::dp_sts_t.
`default_nettype none

module bffa_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              in_kind,
  input  wire bffa_pkg::dp_sts_t sts,
  output bffa_pkg::dp_cmd_t      cmd,
  output logic                   busy
);

  bffa_pkg::state_t state_r, state_nxt;
  logic             clr_resp_r, clr_resp_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= bffa_pkg::ST_CLEAR;
      clr_resp_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_resp_r <= clr_resp_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt    = state_r;
    clr_resp_nxt = clr_resp_r;
    unique case (state_r)
      bffa_pkg::ST_CLEAR: begin
        if (sts.last) begin
          state_nxt    = bffa_pkg::ST_IDLE;
          clr_resp_nxt = 1'b0;
        end
      end
      bffa_pkg::ST_IDLE: begin
        if (start) begin
          if (in_kind == bffa_pkg::KIND_CLEAR) begin
            state_nxt    = bffa_pkg::ST_CLEAR;
            clr_resp_nxt = 1'b1;
          end else begin
            state_nxt = bffa_pkg::ST_READ;
          end
        end
      end
      bffa_pkg::ST_READ: state_nxt = bffa_pkg::ST_CHECK;
      bffa_pkg::ST_CHECK: begin
        if (sts.fit) begin
          state_nxt = bffa_pkg::ST_MARK;
        end else if (sts.last) begin
          state_nxt = bffa_pkg::ST_IDLE;
        end else begin
          state_nxt = bffa_pkg::ST_READ;
        end
      end
      bffa_pkg::ST_MARK: begin
        if (sts.mark_last) begin
          state_nxt = bffa_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bffa_pkg::ST_CLEAR;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      bffa_pkg::ST_CLEAR: begin
        cmd.clr_wr     = 1'b1;
        cmd.resp_clear = sts.last && clr_resp_r;
      end
      bffa_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.init = start;
        cmd.load = start && (in_kind == bffa_pkg::KIND_ALLOC);
      end
      bffa_pkg::ST_READ: cmd.rd = 1'b1;
      bffa_pkg::ST_CHECK: begin
        cmd.chk       = 1'b1;
        cmd.mark_init = sts.fit;
        cmd.resp_fail = !sts.fit && sts.last;
      end
      bffa_pkg::ST_MARK: begin
        cmd.mark_wr    = 1'b1;
        cmd.resp_grant = sts.mark_last;
      end
      default: busy = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/bffa_datapath.sv -----
// Datapath of the bitmap first-fit allocator: segment map memory, scan counters
// and result registers. Uses bffa_pkg for widths and the command/status structs.
`default_nettype none

module bffa_datapath #(
  parameter int HEAP_BYTES    = bffa_pkg::HEAP_BYTES_DEF,
  parameter int SEGMENT_BYTES = bffa_pkg::SEGMENT_BYTES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire bffa_pkg::dp_cmd_t               cmd,
  input  wire logic [bffa_pkg::SIZE_W-1:0]     in_size_bytes,
  output bffa_pkg::dp_sts_t                    sts,
  output logic                                 out_valid,
  output logic                                 out_granted,
  output logic                                 out_failed,
  output logic [bffa_pkg::OFFSET_W-1:0]        out_offset
);

  localparam int NUM_SEGS = HEAP_BYTES / SEGMENT_BYTES;
  localparam int HEAP_EFF = NUM_SEGS * SEGMENT_BYTES;
  localparam int SEG_W    = (NUM_SEGS > 1) ? $clog2(NUM_SEGS) : 1;
  localparam int IDX_W    = $clog2(NUM_SEGS + 1);
  localparam int BYTE_W   = $clog2(HEAP_EFF + 1);
  localparam logic [BYTE_W-1:0] SEG_STEP = BYTE_W'(SEGMENT_BYTES);
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(NUM_SEGS - 1);

  logic                          used_mem [NUM_SEGS];
  logic                          rd_r;
  logic [IDX_W-1:0]              idx_r;
  logic [IDX_W-1:0]              start_idx_r;
  logic [SEG_W-1:0]              end_idx_r;
  logic [BYTE_W-1:0]             pos_r;
  logic [BYTE_W-1:0]             run_bytes_r;
  logic [BYTE_W-1:0]             start_off_r;
  logic [bffa_pkg::SIZE_W-1:0]   size_r;
  logic [BYTE_W-1:0]             run_add;
  logic [BYTE_W-1:0]             pos_add;
  logic [SEG_W-1:0]              addr;

  assign addr    = idx_r[SEG_W-1:0];
  assign run_add = run_bytes_r + SEG_STEP;
  assign pos_add = pos_r + SEG_STEP;

  // A free run of n segments covers the request once n * segment size exceeds
  // the size, which is the same as n reaching size / segment size + 1.
  assign sts.fit       = !rd_r &&
                         (bffa_pkg::CMP_W'(run_add) > bffa_pkg::CMP_W'(size_r));
  assign sts.last      = (idx_r == LAST_IDX);
  assign sts.mark_last = (addr == end_idx_r);

  // Segment map: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      used_mem[addr] <= 1'b0;
    end else if (cmd.mark_wr) begin
      used_mem[addr] <= 1'b1;
    end
    if (cmd.rd) begin
      rd_r <= used_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.init) begin
      idx_r <= '0;
    end else if (cmd.mark_init) begin
      idx_r <= start_idx_r;
    end else if (cmd.clr_wr || cmd.mark_wr || cmd.chk) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      size_r <= in_size_bytes;
    end
    if (cmd.init) begin
      pos_r       <= '0;
      run_bytes_r <= '0;
      start_idx_r <= '0;
      start_off_r <= '0;
    end else if (cmd.chk) begin
      pos_r <= pos_add;
      if (rd_r) begin
        // A used segment: the next candidate run starts just after it.
        run_bytes_r <= '0;
        start_idx_r <= idx_r + 1'b1;
        start_off_r <= pos_add;
      end else begin
        run_bytes_r <= run_add;
        end_idx_r   <= addr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.resp_grant || cmd.resp_fail || cmd.resp_clear;
    end
  end

  always_ff @(posedge clk) begin
    out_granted <= cmd.resp_grant;
    out_failed  <= cmd.resp_fail;
    out_offset  <= cmd.resp_grant ? bffa_pkg::OFFSET_W'(start_off_r) : '0;
  end

endmodule

`default_nettype wire

// ----- dv/tb_bitmap_first_fit_allocator_unit.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the bitmap first-fit segment allocator.
// Depends on bffa_pkg and bitmap_first_fit_allocator_unit from the rtl folder.

module tb_bitmap_first_fit_allocator_unit;
  import bffa_pkg::*;

  localparam int NUM_SEGS     = HEAP_BYTES_DEF / SEGMENT_BYTES_DEF;
  localparam int RANDOM_WORDS = 600;
  localparam int DRAIN_CYCLES = 3 * NUM_SEGS + 32;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic                granted;
    logic                failed;
    logic [OFFSET_W-1:0] offset;
  } alloc_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              in_kind = KIND_ALLOC;
  logic [SIZE_W-1:0] in_size_bytes = '0;
  logic              busy;
  logic              out_valid;
  logic              out_granted;
  logic              out_failed;
  logic [OFFSET_W-1:0] out_offset;

  // Our own view of which segments are taken, and the answers still owed.
  logic [NUM_SEGS-1:0] seg_used = '0;
  alloc_result_t       grant_q[$];
  int                  mismatches = 0;
  int                  burst_left = 0;

  bitmap_first_fit_allocator_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_kind       (in_kind),
    .in_size_bytes (in_size_bytes),
    .out_valid     (out_valid),
    .out_granted   (out_granted),
    .out_failed    (out_failed),
    .out_offset    (out_offset)
  );

  always #6 clk = ~clk;

  initial begin
    #40_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic alloc_result_t predict_alloc(input kind_t kind,
                                                  input logic [SIZE_W-1:0] size);
    alloc_result_t res;
    int            need;
    int            run;
    int            first;
    res   = '0;
    run   = 0;
    first = -1;
    if (kind == KIND_CLEAR) begin
      seg_used = '0;
      return res;
    end
    // Size / segment size (rounded down) plus one segment, and never wrapped.
    need = int'(size) / SEGMENT_BYTES_DEF + 1;
    if (need <= NUM_SEGS) begin
      for (int i = 0; i < NUM_SEGS && first < 0; i++) begin
        if (!seg_used[i]) begin
          run++;
          if (run == need) first = i + 1 - need;
        end else begin
          run = 0;
        end
      end
    end
    if (first >= 0) begin
      for (int i = first; i < first + need; i++) seg_used[i] = 1'b1;
      res.granted = 1'b1;
      res.offset  = OFFSET_W'(first * SEGMENT_BYTES_DEF);
    end else begin
      res.failed = 1'b1;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input alloc_result_t exp_r,
                                 input alloc_result_t got_r);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("%0t: %s: expected granted=%0b failed=%0b offset=%0d, %s",
               $realtime, what, exp_r.granted, exp_r.failed, exp_r.offset,
               $sformatf("got granted=%0b failed=%0b offset=%0d",
                         got_r.granted, got_r.failed, got_r.offset));
  endtask

  // The sender works in bursts, with a gap of random length between bursts.
  task automatic send_word(input kind_t kind, input logic [SIZE_W-1:0] size);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2: gap = 0;
        8, 9:    gap = $urandom_range(13, 800);
        default: gap = $urandom_range(1, 12);
      endcase
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start         <= 1'b1;
    in_kind       <= kind;
    in_size_bytes <= size;
    do @(posedge clk); while (busy !== 1'b0);
    grant_q.push_back(predict_alloc(kind, size));
  endtask

  always @(posedge clk) begin : check_results
    alloc_result_t exp_r;
    alloc_result_t got_r;
    if (rst_n && out_valid === 1'b1) begin
      got_r = '{out_granted, out_failed, out_offset};
      if (grant_q.size() == 0) begin
        report_mismatch("result word with nothing outstanding", '0, got_r);
      end else begin
        exp_r = grant_q.pop_front();
        if (got_r.granted !== exp_r.granted || got_r.failed !== exp_r.failed ||
            got_r.offset !== exp_r.offset)
          report_mismatch("result word differs", exp_r, got_r);
      end
    end
  end

  // Single-segment and two-segment requests on the freshly cleared map.
  task automatic test_segment_edges();
    send_word(KIND_ALLOC, 16'd0);
    send_word(KIND_ALLOC, 16'd15);
    send_word(KIND_ALLOC, 16'd16);
    send_word(KIND_ALLOC, 16'd31);
  endtask

  // A clear frees everything whatever its size field holds.
  task automatic test_clear_word();
    send_word(KIND_CLEAR, 16'hFFFF);
    send_word(KIND_ALLOC, 16'd0);
    send_word(KIND_CLEAR, 16'h5555);
    send_word(KIND_CLEAR, 16'hAAAA);
  endtask

  // Requests for the whole heap and for more than the heap holds.
  task automatic test_whole_heap();
    send_word(KIND_ALLOC, 16'd4095);
    send_word(KIND_ALLOC, 16'd0);
    send_word(KIND_CLEAR, 16'd0);
    send_word(KIND_ALLOC, 16'd4096);
    send_word(KIND_ALLOC, 16'hFFFF);
    send_word(KIND_ALLOC, 16'd4080);
  endtask

  // Fill the heap exactly, so the last segment gives the highest offset.
  task automatic test_exact_fill();
    send_word(KIND_CLEAR, 16'd0);
    send_word(KIND_ALLOC, 16'd4079);
    send_word(KIND_ALLOC, 16'd0);
    send_word(KIND_ALLOC, 16'd0);
    send_word(KIND_ALLOC, 16'hFFFF);
    send_word(KIND_CLEAR, 16'd0);
  endtask

  // Mostly a clear followed by a run of allocations that can fill the heap,
  // with stray clears, huge sizes and allocations on a full map mixed in.
  task automatic test_random_traffic();
    int                random_words;
    int                run_len;
    kind_t             kind;
    logic [SIZE_W-1:0] size;
    random_words = 0;
    while (random_words < RANDOM_WORDS) begin
      if ($urandom_range(0, 99) < 85) begin
        send_word(KIND_CLEAR, SIZE_W'($urandom));
        random_words++;
      end
      run_len = $urandom_range(1, 40);
      for (int k = 0; k < run_len; k++) begin
        kind = ($urandom_range(0, 99) < 3) ? KIND_CLEAR : KIND_ALLOC;
        case ($urandom_range(0, 19))
          14, 15:  size = SIZE_W'($urandom_range(256, 4095));
          16, 17:  size = SIZE_W'($urandom);
          18:      size = SIZE_W'({8'($urandom_range(0, 255)), 4'hF});
          19:      size = SIZE_W'({8'($urandom_range(0, 255)), 4'h0});
          default: size = SIZE_W'($urandom_range(0, 255));
        endcase
        send_word(kind, size);
        random_words++;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_segment_edges();
    test_clear_word();
    test_whole_heap();
    test_exact_fill();
    test_random_traffic();
    start <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && grant_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
